// ===== hdl/assert_macros.svh =====
// assertion helpers used by the datapath, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define OPSIM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define OPSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/opsim_pkg.sv =====
package opsim_pkg;

	// cache size register
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 5'd4;

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BEGIN,
		ST_FETCH,
		ST_CHECK,
		ST_SCAN,
		ST_PICK,
		ST_REPLACE,
		ST_FINISH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic start_run;
		logic check;
		logic scan;
		logic pick;
		logic replace;
		logic finish;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic zero_ways;
		logic hit;
		logic full;
		logic last_pos;
		logic scan_idle;
		logic pick_last;
	} status_t;

endpackage

// ===== hdl/opsim_ctrl.sv =====
module opsim_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last,
	input  opsim_pkg::status_t status,
	output opsim_pkg::cmd_t    cmd,
	output logic               busy,
	output logic               done
);

	opsim_pkg::state_t state_q;
	opsim_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opsim_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			opsim_pkg::ST_LOAD: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (last) begin
						state_nxt = opsim_pkg::ST_BEGIN;
					end
				end
			end
			opsim_pkg::ST_BEGIN: begin
				cmd.start_run = 1'b1;
				state_nxt = status.zero_ways ? opsim_pkg::ST_FINISH : opsim_pkg::ST_FETCH;
			end
			opsim_pkg::ST_FETCH: begin
				state_nxt = opsim_pkg::ST_CHECK;
			end
			opsim_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				if (status.hit || !status.full) begin
					state_nxt = status.last_pos ? opsim_pkg::ST_FINISH : opsim_pkg::ST_FETCH;
				end else begin
					state_nxt = opsim_pkg::ST_SCAN;
				end
			end
			opsim_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_idle) begin
					state_nxt = opsim_pkg::ST_PICK;
				end
			end
			opsim_pkg::ST_PICK: begin
				cmd.pick = 1'b1;
				if (status.pick_last) begin
					state_nxt = opsim_pkg::ST_REPLACE;
				end
			end
			opsim_pkg::ST_REPLACE: begin
				cmd.replace = 1'b1;
				state_nxt = status.last_pos ? opsim_pkg::ST_FINISH : opsim_pkg::ST_FETCH;
			end
			opsim_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nxt  = opsim_pkg::ST_LOAD;
			end
			default: begin
				state_nxt = opsim_pkg::ST_LOAD;
			end
		endcase
	end

	// handshake flags
	assign busy = (state_q != opsim_pkg::ST_LOAD);
	assign done = (state_q == opsim_pkg::ST_FINISH);

endmodule

// ===== hdl/opsim_dp.sv =====
`include "assert_macros.svh"

module opsim_dp #(
	parameter int MAX_REQUESTS = 1024,
	parameter int CACHE_WAYS   = 16,
	parameter int PAGE_BITS    = 16,
	localparam int CNT_W       = $clog2(MAX_REQUESTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  opsim_pkg::cmd_t             cmd,
	input  logic [PAGE_BITS-1:0]        page,
	input  logic                        cfg_we,
	input  logic [opsim_pkg::CFG_W-1:0] cfg_wdata,
	output opsim_pkg::status_t          status,
	output logic [CNT_W-1:0]            hits,
	output logic [CNT_W-1:0]            misses,
	output logic                        overflow
);

	localparam int ADDR_W = $clog2(MAX_REQUESTS);
	localparam int WAY_W  = $clog2(CACHE_WAYS + 1);
	localparam int WIDX_W = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;

	// request store
	logic [PAGE_BITS-1:0] mem [MAX_REQUESTS];
	logic [PAGE_BITS-1:0] mem_rd_q;
	logic [ADDR_W-1:0]    rd_addr;

	logic [opsim_pkg::CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0]            count_q;
	logic                        ovf_q;
	logic [CNT_W-1:0]            pos_q;
	logic [CNT_W-1:0]            scan_addr_q;
	logic [CNT_W-1:0]            hits_q;
	logic [CNT_W-1:0]            misses_q;
	logic [WAY_W-1:0]            filled_q;
	logic [WAY_W-1:0]            unmarked_q;
	logic [CACHE_WAYS-1:0]       marked_q;
	logic [PAGE_BITS-1:0]        resident_q [CACHE_WAYS];
	logic [PAGE_BITS-1:0]        cur_page_q;
	logic                        scan_vld_s1;
	logic [WIDX_W-1:0]           pick_k_q;
	logic [WIDX_W-1:0]           victim_q;
	logic [PAGE_BITS-1:0]        best_q;
	logic                        have_q;

	logic [WAY_W-1:0]      ways;
	logic [WAY_W-1:0]      filled_m1;
	logic [CACHE_WAYS-1:0] hit_vec;
	logic [CACHE_WAYS-1:0] match_new;
	logic                  hit;
	logic                  full;
	logic                  count_ok;
	logic                  issue_ok;
	logic                  take;
	logic                  evict;

	// effective number of ways, saturated to the array size
	always_comb begin
		if (32'(cfg_q) > CACHE_WAYS) begin
			ways = WAY_W'(CACHE_WAYS);
		end else begin
			ways = WAY_W'(cfg_q);
		end
	end

	// parallel compare of the fetched page against every resident way
	always_comb begin
		for (int j = 0; j < CACHE_WAYS; j++) begin
			hit_vec[j] = (j < int'(filled_q)) && (resident_q[j] == mem_rd_q);
		end
	end

	assign match_new = hit_vec & ~marked_q;
	assign hit       = |hit_vec;
	assign full      = (filled_q == ways);
	assign evict     = !hit && full;
	assign count_ok  = (count_q < CNT_W'(MAX_REQUESTS));
	assign issue_ok  = (scan_addr_q != count_q) && (unmarked_q > WAY_W'(1));
	assign filled_m1 = filled_q - WAY_W'(1);
	assign take      = !marked_q[pick_k_q] && (!have_q || (resident_q[pick_k_q] > best_q));
	assign rd_addr   = cmd.scan ? scan_addr_q[ADDR_W-1:0] : pos_q[ADDR_W-1:0];

	// status back to the controller
	always_comb begin
		status.zero_ways = (ways == '0);
		status.hit       = hit;
		status.full      = full;
		status.last_pos  = ((pos_q + CNT_W'(1)) == count_q);
		status.scan_idle = !issue_ok && !scan_vld_s1;
		status.pick_last = (WAY_W'(pick_k_q) == filled_m1);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= opsim_pkg::CACHE_SIZE_RST;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// request store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && count_ok) begin
			mem[count_q[ADDR_W-1:0]] <= page;
		end
		mem_rd_q <= mem[rd_addr];
	end

	// request count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.finish) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (count_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// replay position, tallies and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			filled_q <= '0;
		end else if (cmd.start_run) begin
			pos_q    <= '0;
			hits_q   <= '0;
			misses_q <= (ways == '0) ? count_q : '0;
			filled_q <= '0;
		end else if (cmd.check) begin
			if (hit) begin
				hits_q <= hits_q + CNT_W'(1);
			end else begin
				misses_q <= misses_q + CNT_W'(1);
			end
			if (!evict) begin
				pos_q <= pos_q + CNT_W'(1);
			end
			if (!hit && !full) begin
				filled_q <= filled_q + WAY_W'(1);
			end
		end else if (cmd.replace) begin
			pos_q <= pos_q + CNT_W'(1);
		end
	end

	// forward scan for next uses, one stored request per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			unmarked_q  <= '0;
			marked_q    <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan && issue_ok;
			if (cmd.check && evict) begin
				scan_addr_q <= pos_q + CNT_W'(1);
				unmarked_q  <= filled_q;
				marked_q    <= '0;
			end else if (cmd.scan) begin
				if (issue_ok) begin
					scan_addr_q <= scan_addr_q + CNT_W'(1);
				end
				// the way seen last keeps its candidacy
				if (scan_vld_s1 && (unmarked_q > WAY_W'(1)) && (|match_new)) begin
					marked_q   <= marked_q | match_new;
					unmarked_q <= unmarked_q - WAY_W'(1);
				end
			end
		end
	end

	// victim search over unmarked ways, largest page wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_k_q <= '0;
			have_q   <= 1'b0;
			victim_q <= '0;
		end else if (cmd.check && evict) begin
			pick_k_q <= '0;
			have_q   <= 1'b0;
		end else if (cmd.pick) begin
			if (take) begin
				victim_q <= pick_k_q;
				have_q   <= 1'b1;
			end
			pick_k_q <= pick_k_q + WIDX_W'(1);
		end
	end

	// page data of the search and of the current request
	always_ff @(posedge clk) begin
		if (cmd.pick && take) begin
			best_q <= resident_q[pick_k_q];
		end
		if (cmd.check) begin
			cur_page_q <= mem_rd_q;
		end
	end

	// resident pages: fill an empty way or overwrite the victim
	always_ff @(posedge clk) begin
		if (cmd.check && !hit && !full) begin
			resident_q[filled_q[WIDX_W-1:0]] <= mem_rd_q;
		end else if (cmd.replace) begin
			resident_q[victim_q] <= cur_page_q;
		end
	end

	assign hits     = hits_q;
	assign misses   = misses_q;
	assign overflow = ovf_q;

	// checks
	`OPSIM_ASSERT(a_scan_keeps_candidate, !cmd.scan || (unmarked_q != '0), "scan lost all candidates")
	`OPSIM_ASSERT(a_fill_bounded, !cmd.check || (filled_q <= ways), "fill count beyond cache size")
	`OPSIM_ASSERT(a_victim_chosen, !cmd.replace || have_q, "replace without a victim")
	`OPSIM_ASSERT(a_tally_matches, !cmd.finish || (((CNT_W+1)'(hits_q) + (CNT_W+1)'(misses_q)) == (CNT_W+1)'(count_q)), "hits and misses do not cover the sequence")
	`OPSIM_ASSERT_NEXT(a_clear_after_result, cmd.finish, (count_q == '0) && !ovf_q, "state not cleared after result")

endmodule

// ===== hdl/optimal_page_replacement_sim.sv =====
// after the last request a set-up state, then each replayed request is fetched and checked
// on a hit or a fill, then done is raised with the result; a zero cache size skips replay
// a miss with a full cache adds a forward scan over the stored requests that stops once a
// single candidate is left or they run out, then a pick over the filled ways and a replace
// throughput: one request per cycle while loading, busy stays high until the result cycle ends
// reset: asynchronous, active low; clears counts, cache size back to 4; receiver cannot stall
module optimal_page_replacement_sim #(
	parameter int MAX_REQUESTS = 1024,
	parameter int CACHE_WAYS   = 16,
	parameter int PAGE_BITS    = 16,
	localparam int CNT_W       = $clog2(MAX_REQUESTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [PAGE_BITS-1:0]        page,
	input  logic                        last,
	input  logic                        cfg_we,
	input  logic [opsim_pkg::CFG_W-1:0] cfg_wdata,
	output logic                        done,
	output logic [CNT_W-1:0]            hits,
	output logic [CNT_W-1:0]            misses,
	output logic                        overflow
);

	opsim_pkg::cmd_t    cmd;
	opsim_pkg::status_t status;

	// sequencer
	opsim_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// request store, cache ways and tallies
	opsim_dp #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.CACHE_WAYS   (CACHE_WAYS),
		.PAGE_BITS    (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.page      (page),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.hits      (hits),
		.misses    (misses),
		.overflow  (overflow)
	);

endmodule
